FILE: rtl/core/sws_pkg.sv
// Shared types and constants for the sliding-window sender.
package sws_pkg;

  localparam int SEQ_COUNT    = 8;
  localparam int SEQ_W        = 3;
  localparam int MAX_WINDOW   = 4;
  localparam int PAYLOAD_BITS = 64;
  localparam int DUP_W        = 4;
  localparam int LIMIT_W      = 3;
  localparam int CFG_DATA_W   = 4;

  localparam int LIMIT_CAP_INT = (MAX_WINDOW < SEQ_COUNT - 1) ? MAX_WINDOW : SEQ_COUNT - 1;
  localparam logic [LIMIT_W-1:0] LIMIT_CAP          = LIMIT_W'(LIMIT_CAP_INT);
  localparam logic [LIMIT_W-1:0] WINDOW_LIMIT_RESET = LIMIT_W'(4);
  localparam logic [DUP_W-1:0]   DUP_THR_RESET      = DUP_W'(3);
  localparam logic [DUP_W-1:0]   DUP_MAX            = DUP_W'(15);

  typedef enum logic [1:0] {
    CMD_SEND    = 2'd0,
    CMD_ACK     = 2'd1,
    CMD_TIMEOUT = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [0:0] {
    CFG_WINDOW_LIMIT = 1'b0,
    CFG_DUP_THR      = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic             accepted;
    logic             tx_valid;
    logic [SEQ_W-1:0] tx_seq;
    logic             stop_valid;
    logic [SEQ_W-1:0] stop_seq;
    logic             start_valid;
    logic [SEQ_W-1:0] start_seq;
    logic             window_full;
    logic [SEQ_W-1:0] in_flight;
  } result_t;

endpackage

FILE: rtl/core/sws_ctrl.sv
// Controller state machine: input capture, execution and result transfer.
module sws_ctrl import sws_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      out_stall_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  output ctrl_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_RESP = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = ST_RESP;
      end
      ST_RESP: begin
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_RESP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/core/sws_dp.sv
// Datapath: window pointers, duplicate counter, payload store and result registers.
module sws_dp import sws_pkg::*; #(
  parameter int PAYLOAD_BITS = sws_pkg::PAYLOAD_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ctrl_cmd_t               cmd_i,
  input  logic                    cfg_we_i,
  input  cfg_idx_e                cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  input  logic [1:0]              command_i,
  input  logic [PAYLOAD_BITS-1:0] payload_i,
  input  logic [SEQ_W-1:0]        ack_number_i,
  input  logic                    checksum_ok_i,
  input  logic [SEQ_W-1:0]        timer_id_i,
  output result_t                 res_o,
  output logic [PAYLOAD_BITS-1:0] tx_payload_o
);

  logic [SEQ_W-1:0]        base_q, base_d, next_q, next_d;
  logic [DUP_W-1:0]        dup_q, dup_d;
  logic [LIMIT_W-1:0]      wl_q;
  logic [DUP_W-1:0]        thr_q;
  cmd_e                    cmd_q;
  logic [PAYLOAD_BITS-1:0] data_q;
  logic [SEQ_W-1:0]        ack_q, tid_q;
  logic                    ck_q;
  logic [PAYLOAD_BITS-1:0] rd_q;
  logic [PAYLOAD_BITS-1:0] mem_q [SEQ_COUNT];
  result_t                 res_q, res_d;
  logic [PAYLOAD_BITS-1:0] txp_q, txp_d;

  logic [SEQ_W-1:0]        n, n_new, off, base_m1, lim;
  logic [DUP_W-1:0]        dup_inc;
  logic                    wr_en;

  always_comb begin
    n       = next_q - base_q;
    lim     = (wl_q > LIMIT_CAP) ? SEQ_W'(LIMIT_CAP) : SEQ_W'(wl_q);
    off     = ack_q - base_q;
    base_m1 = base_q - SEQ_W'(1);
    dup_inc = (dup_q == DUP_MAX) ? dup_q : dup_q + DUP_W'(1);
    base_d  = base_q;
    next_d  = next_q;
    dup_d   = dup_q;
    wr_en   = 1'b0;
    res_d   = '0;
    txp_d   = '0;
    case (cmd_q)
      CMD_SEND: begin
        if (n < lim) begin
          wr_en           = 1'b1;
          res_d.accepted  = 1'b1;
          res_d.tx_valid  = 1'b1;
          res_d.tx_seq    = next_q;
          txp_d           = data_q;
          if (n == '0) begin
            res_d.start_valid = 1'b1;
            res_d.start_seq   = next_q;
          end
          next_d = next_q + SEQ_W'(1);
        end
      end
      CMD_ACK: begin
        if (ck_q) begin
          if (off < n) begin
            res_d.stop_valid = 1'b1;
            res_d.stop_seq   = base_q;
            base_d           = ack_q + SEQ_W'(1);
            dup_d            = '0;
            if (next_q != base_d) begin
              res_d.start_valid = 1'b1;
              res_d.start_seq   = base_d;
            end
          end else if (ack_q == base_m1) begin
            dup_d = dup_inc;
            if (dup_inc >= thr_q && n != '0) begin
              res_d.tx_valid = 1'b1;
              res_d.tx_seq   = base_q;
              txp_d          = rd_q;
              dup_d          = '0;
            end
          end
        end
      end
      CMD_TIMEOUT: begin
        res_d.stop_valid  = 1'b1;
        res_d.stop_seq    = tid_q;
        res_d.start_valid = 1'b1;
        res_d.start_seq   = tid_q;
        if (n != '0) begin
          res_d.tx_valid = 1'b1;
          res_d.tx_seq   = base_q;
          txp_d          = rd_q;
        end
      end
      default: begin
      end
    endcase
    n_new             = next_d - base_d;
    res_d.in_flight   = n_new;
    res_d.window_full = (n_new >= lim);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q  <= cmd_e'(command_i);
      data_q <= payload_i;
      ack_q  <= ack_number_i;
      ck_q   <= checksum_ok_i;
      tid_q  <= timer_id_i;
      rd_q   <= mem_q[base_q];
    end
    if (cmd_i.exec && wr_en) begin
      mem_q[next_q] <= data_q;
    end
    if (cmd_i.exec) begin
      res_q <= res_d;
      txp_q <= txp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      next_q <= '0;
      dup_q  <= '0;
      wl_q   <= WINDOW_LIMIT_RESET;
      thr_q  <= DUP_THR_RESET;
    end else begin
      if (cmd_i.exec) begin
        base_q <= base_d;
        next_q <= next_d;
        dup_q  <= dup_d;
      end
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_WINDOW_LIMIT: wl_q  <= cfg_data_i[LIMIT_W-1:0];
          CFG_DUP_THR:      thr_q <= cfg_data_i[DUP_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  assign res_o        = res_q;
  assign tx_payload_o = txp_q;

endmodule

FILE: rtl/core/sliding_window_sender.sv
// Top level of the sliding-window sender.
// The controller takes an item, executes it against the registered store read, then
//   holds the result in its response state until it is transferred; no new item is
//   taken before that transfer.
// Reset: asynchronous, active low; pointers and duplicate count clear, registers
//   return to window limit 4 and threshold 3; the payload store is not cleared.
module sliding_window_sender import sws_pkg::*; #(
  parameter int PAYLOAD_BITS = sws_pkg::PAYLOAD_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              command_i,
  input  logic [PAYLOAD_BITS-1:0] payload_i,
  input  logic [SEQ_W-1:0]        ack_number_i,
  input  logic                    checksum_ok_i,
  input  logic [SEQ_W-1:0]        timer_id_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    accepted_o,
  output logic                    tx_valid_o,
  output logic [SEQ_W-1:0]        tx_seq_o,
  output logic [PAYLOAD_BITS-1:0] tx_payload_o,
  output logic                    stop_valid_o,
  output logic [SEQ_W-1:0]        stop_seq_o,
  output logic                    start_valid_o,
  output logic [SEQ_W-1:0]        start_seq_o,
  output logic                    window_full_o,
  output logic [SEQ_W-1:0]        in_flight_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [0:0]              cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i
);

  ctrl_cmd_t ctrl_cmd;
  result_t   res;

  assign cfg_ready_o = 1'b1;

  sws_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (ctrl_cmd)
  );

  sws_dp #(
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (ctrl_cmd),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_idx_e'(cfg_index_i)),
    .cfg_data_i    (cfg_data_i),
    .command_i     (command_i),
    .payload_i     (payload_i),
    .ack_number_i  (ack_number_i),
    .checksum_ok_i (checksum_ok_i),
    .timer_id_i    (timer_id_i),
    .res_o         (res),
    .tx_payload_o  (tx_payload_o)
  );

  assign accepted_o    = res.accepted;
  assign tx_valid_o    = res.tx_valid;
  assign tx_seq_o      = res.tx_seq;
  assign stop_valid_o  = res.stop_valid;
  assign stop_seq_o    = res.stop_seq;
  assign start_valid_o = res.start_valid;
  assign start_seq_o   = res.start_seq;
  assign window_full_o = res.window_full;
  assign in_flight_o   = res.in_flight;

endmodule

FILE: rtl/core/sws_checker.sv
// Port-level assertions for the sliding-window sender and their binding.
module sws_checker import sws_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic             accepted_o,
  input logic             tx_valid_o,
  input logic [SEQ_W-1:0] tx_seq_o,
  input logic [SEQ_W-1:0] in_flight_o
);

  a_inflight_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (in_flight_o <= SEQ_W'(LIMIT_CAP)))
    else $error("in_flight exceeds window cap");

  a_accept_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && accepted_o) |-> tx_valid_o)
    else $error("accepted send without transmission");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (in_stall_o && !out_valid_o))
    else $error("block not busy after input transfer");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(tx_seq_o)))
    else $error("stalled result changed");

endmodule

bind sliding_window_sender sws_checker u_sws_checker (.*);
